[design/modular_division_fermat_prime_top_defines.svh]
// ----------------------------------------------------------------------------
// Modular divider assertion macros
// Shared assertion helpers; define NO_ASSERTIONS to leave them out.
// ----------------------------------------------------------------------------
`ifndef MODULAR_DIVISION_FERMAT_PRIME_TOP_DEFINES_SVH
`define MODULAR_DIVISION_FERMAT_PRIME_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define MDF_ASSERT_IMPL(lbl, clk_sig, rst_n_sig, ante, cons) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) \
		(ante) |-> (cons)) else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define MDF_ASSERT_NEXT(lbl, clk_sig, rst_n_sig, ante, cons) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) \
		(ante) |=> (cons)) else $error("assertion failed");
`else
`define MDF_ASSERT_IMPL(lbl, clk_sig, rst_n_sig, ante, cons)
`define MDF_ASSERT_NEXT(lbl, clk_sig, rst_n_sig, ante, cons)
`endif

`endif

[design/mdf_pkg.sv]
// ----------------------------------------------------------------------------
// Modular divider package
// Field constants, Barrett reduction constants and the item passed along the
// exponentiation chain.
// ----------------------------------------------------------------------------
package mdf_pkg;

	localparam int unsigned RES_W = 30;
	localparam int unsigned N_BITS = 30;
	localparam int unsigned MM_LAT = 4;

	localparam logic [RES_W-1:0] PRIME = 30'd998244353;
	localparam logic [RES_W-1:0] INV_EXP = 30'd998244351;
	localparam logic [31:0] PRIME_X1 = 32'd998244353;
	localparam logic [31:0] PRIME_X2 = 32'd1996488706;
	// Barrett constant floor(2^60 / prime).
	localparam logic [30:0] BARRETT_MU = 31'(64'h1000_0000_0000_0000 / 64'd998244353);

	typedef logic [RES_W-1:0] res_t;

	typedef struct packed {
		logic valid;
		res_t acc;
		res_t base;
		res_t num;
	} item_t;

endpackage

[design/mdf_mulmod.sv]
// ----------------------------------------------------------------------------
// Pipelined modular multiplier
// Four-stage product modulo the prime using Barrett reduction.
// ----------------------------------------------------------------------------
module mdf_mulmod (
	input  logic            clk,
	input  logic            en,
	input  mdf_pkg::res_t   a,
	input  mdf_pkg::res_t   b,
	output mdf_pkg::res_t   r
);

	logic [59:0] prod;
	logic [59:0] z_s1;
	logic [61:0] t;
	logic [61:0] t_s2;
	logic [31:0] zlo_s2;
	logic [60:0] qp;
	logic [31:0] r_s3;
	logic [31:0] r_s4;

	assign prod = 60'(a) * 60'(b);
	assign t = 62'(z_s1[59:29]) * 62'(mdf_pkg::BARRETT_MU);
	assign qp = 61'(t_s2[61:31]) * 61'(mdf_pkg::PRIME);

	// The estimated quotient is at most two short, so the remainder stays
	// below three times the prime and fits in 32 bits.
	always_ff @(posedge clk) begin
		if (en) begin
			z_s1 <= prod;
			t_s2 <= t;
			zlo_s2 <= z_s1[31:0];
			r_s3 <= zlo_s2 - qp[31:0];
			if (r_s3 >= mdf_pkg::PRIME_X2) begin
				r_s4 <= r_s3 - mdf_pkg::PRIME_X2;
			end else if (r_s3 >= mdf_pkg::PRIME_X1) begin
				r_s4 <= r_s3 - mdf_pkg::PRIME_X1;
			end else begin
				r_s4 <= r_s3;
			end
		end
	end

	assign r = r_s4[29:0];

endmodule

[design/mdf_cell.sv]
// ----------------------------------------------------------------------------
// Square-and-multiply cell
// Handles one exponent bit: squares the base and, when the bit is set,
// multiplies it into the accumulator.
// ----------------------------------------------------------------------------
module mdf_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            mul_bit,
	input  mdf_pkg::item_t  d,
	output mdf_pkg::item_t  q
);

	localparam int unsigned LAT = mdf_pkg::MM_LAT;

	mdf_pkg::res_t acc_prod;
	mdf_pkg::res_t base_sq;
	logic [LAT-1:0] vld_q;
	mdf_pkg::res_t num_q [LAT];
	mdf_pkg::res_t acc_q [LAT];

	mdf_mulmod u_acc_mul (
		.clk (clk),
		.en  (en),
		.a   (d.acc),
		.b   (d.base),
		.r   (acc_prod)
	);

	mdf_mulmod u_base_sq (
		.clk (clk),
		.en  (en),
		.a   (d.base),
		.b   (d.base),
		.r   (base_sq)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], d.valid};
		end
	end

	// The dividend and the unmultiplied accumulator ride alongside the
	// multipliers so that everything leaves the cell in the same cycle.
	always_ff @(posedge clk) begin
		if (en) begin
			num_q[0] <= d.num;
			acc_q[0] <= d.acc;
			for (int i = 1; i < LAT; i++) begin
				num_q[i] <= num_q[i-1];
				acc_q[i] <= acc_q[i-1];
			end
		end
	end

	always_comb begin
		q.valid = vld_q[LAT-1];
		q.num = num_q[LAT-1];
		q.base = base_sq;
		q.acc = mul_bit ? acc_prod : acc_q[LAT-1];
	end

endmodule

[design/modular_division_fermat_prime_top.sv]
// ----------------------------------------------------------------------------
// Modular divider over the prime 998244353
// Streams dividend and divisor pairs and returns dividend / divisor mod prime.
// ----------------------------------------------------------------------------
// The block takes one request per clock while req_stall is low and returns
// one quotient per request, in order. The inverse of the divisor is its power
// prime-2, built by a row of 30 square-and-multiply cells, one per exponent
// bit, followed by one more modular multiply by the dividend. Each modular
// multiply is a 4-stage pipeline, so a request passes 125 register stages (31
// multiplies of 4 stages plus the output register), the first of them loaded
// at the accepting edge. A zero divisor gives a zero quotient. While the
// result side stalls, one extra result is held in a skid register as
// req_stall rises, freezing the whole row until the result side drains.
// ----------------------------------------------------------------------------
`include "modular_division_fermat_prime_top_defines.svh"

module modular_division_fermat_prime_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  logic [29:0]   dividend,
	input  logic [29:0]   divisor,
	output logic          res_valid,
	input  logic          res_stall,
	output logic [29:0]   quotient
);

	localparam int unsigned NB = mdf_pkg::N_BITS;
	localparam int unsigned LAT = mdf_pkg::MM_LAT;

	mdf_pkg::item_t chain [NB+1];
	logic en;
	logic [LAT-1:0] fin_vld_q;
	mdf_pkg::res_t fin_prod;
	logic tail_valid;
	logic res_valid_q;
	logic skid_full_q;
	mdf_pkg::res_t res_q;
	mdf_pkg::res_t skid_q;

	assign en = !skid_full_q;
	assign req_stall = skid_full_q;

	always_comb begin
		chain[0].valid = req_valid && !skid_full_q;
		chain[0].acc = mdf_pkg::res_t'(1);
		chain[0].base = divisor;
		chain[0].num = dividend;
	end

	for (genvar i = 0; i < NB; i++) begin : g_cell
		mdf_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.mul_bit (mdf_pkg::INV_EXP[i]),
			.d       (chain[i]),
			.q       (chain[i+1])
		);
	end

	mdf_mulmod u_final_mul (
		.clk (clk),
		.en  (en),
		.a   (chain[NB].num),
		.b   (chain[NB].acc),
		.r   (fin_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_vld_q <= '0;
		end else if (en) begin
			fin_vld_q <= {fin_vld_q[LAT-2:0], chain[NB].valid};
		end
	end

	assign tail_valid = fin_vld_q[LAT-1];

	// Output register with a one-entry skid behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (!skid_full_q) begin
			if (!res_valid_q || !res_stall) begin
				res_valid_q <= tail_valid;
			end else if (tail_valid) begin
				skid_full_q <= 1'b1;
			end
		end else if (!res_stall) begin
			skid_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_full_q) begin
			if (!res_valid_q || !res_stall) begin
				res_q <= fin_prod;
			end else begin
				skid_q <= fin_prod;
			end
		end else if (!res_stall) begin
			res_q <= skid_q;
		end
	end

	assign res_valid = res_valid_q;
	assign quotient = res_q;

	`MDF_ASSERT_IMPL(a_skid_behind_output, clk, arst_n, skid_full_q, res_valid_q)
	`MDF_ASSERT_NEXT(a_skid_catches_tail, clk, arst_n,
		res_valid_q && res_stall && !skid_full_q && tail_valid, skid_full_q)
	`MDF_ASSERT_NEXT(a_skid_drain_keeps_valid, clk, arst_n,
		skid_full_q && !res_stall, res_valid_q && !skid_full_q)
	`MDF_ASSERT_IMPL(a_quotient_reduced, clk, arst_n, res_valid_q,
		res_q < mdf_pkg::PRIME)

endmodule
